>>> rtl/vms_pkg.sv
// vms_pkg: word types, control struct and fixed constants shared by the
// von Mises stress pipeline. No dependencies.
package vms_pkg;

    localparam int unsigned ROW_BITS     = 60;
    localparam int unsigned TAG_BITS     = 16;
    localparam int unsigned DENSITY_BITS = 16;
    localparam int unsigned RESULT_BITS  = 32;

    localparam logic [DENSITY_BITS-1:0] REST_DENSITY_RESET = 16'd1000;

    typedef struct packed {
        logic [TAG_BITS-1:0]     particle_tag;
        logic [ROW_BITS-1:0]     deform_row0;
        logic [ROW_BITS-1:0]     deform_row1;
        logic [ROW_BITS-1:0]     deform_row2;
        logic [ROW_BITS-1:0]     stress_row0;
        logic [ROW_BITS-1:0]     stress_row1;
        logic [ROW_BITS-1:0]     stress_row2;
        logic [DENSITY_BITS-1:0] current_density;
    } t_vms_in;

    typedef struct packed {
        logic [TAG_BITS-1:0]    result_tag;
        logic [RESULT_BITS-1:0] equivalent_stress;
        logic                   saturated;
    } t_vms_out;

    // valid and tag travelling alongside the data of a stage
    typedef struct packed {
        logic                valid;
        logic [TAG_BITS-1:0] tag;
    } t_vms_ctl;

endpackage

>>> rtl/vms_cauchy.sv
// vms_cauchy: eight-stage front end; scaled Cauchy stress and the exact
// von Mises quadratic form. Depends on vms_pkg.
module vms_cauchy import vms_pkg::*; #(
    parameter int unsigned E = 20,
    parameter int unsigned QW = 2 * (2 * E + 19) + 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  t_vms_in       i_item,
    output t_vms_ctl      o_ctl,
    output logic [QW-1:0] o_q
);

    localparam int unsigned PW = 2 * E;
    localparam int unsigned AW = 2 * E + 2;
    localparam int unsigned SW = AW + DENSITY_BITS;
    localparam int unsigned DW = SW + 1;
    localparam int unsigned AL = AW / 2;
    localparam int unsigned AH = AW - AL;
    localparam int unsigned LW = (DW + 1) / 2;
    localparam int unsigned HW = DW - LW;

    // entries used: diagonal, then upper-triangle shears
    localparam int EI [6] = '{0, 1, 2, 0, 0, 1};
    localparam int EJ [6] = '{0, 1, 2, 1, 2, 2};

    logic [63:0]           fr64 [3];
    logic [63:0]           pr64 [3];
    logic signed [E-1:0]   f [3][3];
    logic signed [E-1:0]   p [3][3];

    assign fr64[0] = 64'(i_item.deform_row0);
    assign fr64[1] = 64'(i_item.deform_row1);
    assign fr64[2] = 64'(i_item.deform_row2);
    assign pr64[0] = 64'(i_item.stress_row0);
    assign pr64[1] = 64'(i_item.stress_row1);
    assign pr64[2] = 64'(i_item.stress_row2);

    for (genvar r = 0; r < 3; r++) begin : g_row
        for (genvar c = 0; c < 3; c++) begin : g_col
            assign f[r][c] = signed'(fr64[r][c*E +: E]);
            assign p[r][c] = signed'(pr64[r][c*E +: E]);
        end
    end

    t_vms_ctl r_ctl [8];
    logic [DENSITY_BITS-1:0] r_rho1, r_rho2;
    logic signed [PW-1:0]    r_prod [6][3];
    logic signed [AW-1:0]    r_acc  [6];
    logic [AL+DENSITY_BITS-1:0]        r_plo [6];
    logic signed [AH+DENSITY_BITS:0]   r_phi [6];
    logic signed [SW-1:0]    r_s    [6];
    logic [DW-1:0]           r_mag  [6];
    logic [2*LW-1:0]         r_ll   [6];
    logic [LW+HW-1:0]        r_lh   [6];
    logic [2*HW-1:0]         r_hh   [6];
    logic [QW-1:0]           r_sq   [6];
    logic [QW-1:0]           r_q;

    logic signed [DW-1:0]    n_diff [6];
    logic [QW-1:0]           n_norm, n_shear;

    always_comb begin
        n_diff[0] = DW'(r_s[0]) - DW'(r_s[1]);
        n_diff[1] = DW'(r_s[1]) - DW'(r_s[2]);
        n_diff[2] = DW'(r_s[0]) - DW'(r_s[2]);
        n_diff[3] = DW'(r_s[3]);
        n_diff[4] = DW'(r_s[4]);
        n_diff[5] = DW'(r_s[5]);
        n_norm    = (r_sq[0] + r_sq[1] + r_sq[2]) >> 1;
        n_shear   = r_sq[3] + r_sq[4] + r_sq[5];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 8; k++) r_ctl[k] <= '0;
        end else begin
            r_ctl[0] <= '{valid: i_valid, tag: i_item.particle_tag};
            for (int k = 1; k < 8; k++) r_ctl[k] <= r_ctl[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rho1 <= i_item.current_density;
        r_rho2 <= r_rho1;
        for (int e = 0; e < 6; e++) begin
            for (int k = 0; k < 3; k++) begin
                r_prod[e][k] <= p[EI[e]][k] * f[EJ[e]][k];
            end
            r_acc[e] <= AW'(r_prod[e][0]) + AW'(r_prod[e][1]) + AW'(r_prod[e][2]);
            r_plo[e] <= r_acc[e][AL-1:0] * r_rho2;
            r_phi[e] <= signed'(r_acc[e][AW-1:AL]) * signed'({1'b0, r_rho2});
            r_s[e]   <= (SW'(r_phi[e]) <<< AL) + SW'(signed'({1'b0, r_plo[e]}));
            r_mag[e] <= n_diff[e][DW-1] ? DW'(-n_diff[e]) : DW'(n_diff[e]);
            r_ll[e]  <= r_mag[e][LW-1:0] * r_mag[e][LW-1:0];
            r_lh[e]  <= r_mag[e][LW-1:0] * r_mag[e][DW-1:LW];
            r_hh[e]  <= r_mag[e][DW-1:LW] * r_mag[e][DW-1:LW];
            r_sq[e]  <= (QW'(r_hh[e]) << (2 * LW)) + (QW'(r_lh[e]) << (LW + 1))
                        + QW'(r_ll[e]);
        end
        r_q <= n_norm + (n_shear << 1) + n_shear;
    end

    assign o_ctl = r_ctl[7];
    assign o_q   = r_q;

endmodule

>>> rtl/vms_isqrt.sv
// vms_isqrt: pipelined integer square root, one result bit per stage.
// Depends on vms_pkg.
module vms_isqrt import vms_pkg::*; #(
    parameter int unsigned QW = 120
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_vms_ctl         i_ctl,
    input  logic [QW-1:0]    i_q,
    output t_vms_ctl         o_ctl,
    output logic [QW/2-1:0]  o_root
);

    localparam int unsigned RW = QW / 2;

    t_vms_ctl      r_ctl  [RW];
    logic [QW-1:0] r_rem  [RW];
    logic [RW-1:0] r_root [RW];

    for (genvar g = 0; g < RW; g++) begin : g_stage
        localparam int unsigned B = RW - 1 - g;
        t_vms_ctl      ctl_in;
        logic [QW-1:0] rem_in, delta;
        logic [RW-1:0] root_in;

        if (g == 0) begin : g_first
            assign ctl_in  = i_ctl;
            assign rem_in  = i_q;
            assign root_in = '0;
        end else begin : g_next
            assign ctl_in  = r_ctl[g-1];
            assign rem_in  = r_rem[g-1];
            assign root_in = r_root[g-1];
        end

        // (root + 2^B)^2 - root^2, lower root bits are still zero
        assign delta = (QW'(root_in) << (B + 1)) | (QW'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[g] <= '0;
            end else begin
                r_ctl[g] <= ctl_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (rem_in >= delta) begin
                r_rem[g]  <= rem_in - delta;
                r_root[g] <= root_in | (RW'(1) << B);
            end else begin
                r_rem[g]  <= rem_in;
                r_root[g] <= root_in;
            end
        end
    end

    assign o_ctl  = r_ctl[RW-1];
    assign o_root = r_root[RW-1];

endmodule

>>> rtl/vms_div.sv
// vms_div: pipelined restoring divider, one quotient bit per stage; divides
// the root, less its fraction bits, by the rest density. Depends on vms_pkg.
module vms_div import vms_pkg::*; #(
    parameter int unsigned RW = 60,
    parameter int unsigned F  = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_vms_ctl                i_ctl,
    input  logic [RW-1:0]           i_root,
    input  logic [DENSITY_BITS-1:0] i_divisor,
    output t_vms_ctl                o_ctl,
    output logic [RW-F-1:0]         o_quo
);

    localparam int unsigned NW = RW - F;

    t_vms_ctl                r_ctl [NW];
    logic [DENSITY_BITS-1:0] r_rem [NW];
    logic [NW-1:0]           r_num [NW];
    logic [NW-1:0]           r_quo [NW];

    for (genvar g = 0; g < NW; g++) begin : g_stage
        t_vms_ctl                ctl_in;
        logic [DENSITY_BITS-1:0] rem_in;
        logic [NW-1:0]           num_in, quo_in;
        logic [DENSITY_BITS:0]   trial;
        logic                    ge;

        if (g == 0) begin : g_first
            assign ctl_in = i_ctl;
            assign rem_in = '0;
            assign num_in = i_root[RW-1:F];
            assign quo_in = '0;
        end else begin : g_next
            assign ctl_in = r_ctl[g-1];
            assign rem_in = r_rem[g-1];
            assign num_in = r_num[g-1];
            assign quo_in = r_quo[g-1];
        end

        assign trial = {rem_in, num_in[NW-1]};
        assign ge    = trial >= {1'b0, i_divisor};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[g] <= '0;
            end else begin
                r_ctl[g] <= ctl_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g] <= ge ? DENSITY_BITS'(trial - {1'b0, i_divisor})
                           : trial[DENSITY_BITS-1:0];
            r_num[g] <= num_in << 1;
            r_quo[g] <= {quo_in[NW-2:0], ge};
        end
    end

    assign o_ctl = r_ctl[NW-1];
    assign o_quo = r_quo[NW-1];

endmodule

>>> rtl/von_mises_stress_from_pk1.sv
// von_mises_stress_from_pk1: top level of the von Mises stress pipeline.
// Depends on vms_pkg, vms_cauchy, vms_isqrt and vms_div.
//
// Usage:
//  - Input: drive a word on i_item and raise start; it is taken at any edge
//    with start high and busy low. busy stays low, so one word a cycle.
//  - Config: i_cfg_we with i_cfg_wdata writes rest_density at that edge
//    (zero acts as one). Write only while no word is in flight.
//  - Output: o_strobe is high for one cycle with o_result; the receiver
//    cannot stall, so nothing is ever held back.
//  - Pipeline: a word passes the stress and quadratic-form stages, the
//    square-root stages (root width RW), the divider stages (quotient
//    width RW-F) and the output register, with RW = 2*ELEMENT_BITS+20
//    and F = DEFORM_FRACTION_BITS. Throughput is one word a cycle, set by
//    the fully pipelined root and divide stages.
//  - Reset clears all valid bits (no strobe until a new word) and sets
//    rest_density to 1000.
module von_mises_stress_from_pk1 import vms_pkg::*; #(
    parameter int unsigned ELEMENT_BITS         = 20,
    parameter int unsigned DEFORM_FRACTION_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  t_vms_in                 i_item,
    input  logic                    i_cfg_we,
    input  logic [DENSITY_BITS-1:0] i_cfg_wdata,
    output logic                    o_strobe,
    output t_vms_out                o_result
);

    localparam int unsigned DW = 2 * ELEMENT_BITS + 19;
    localparam int unsigned QW = 2 * DW + 2;
    localparam int unsigned RW = QW / 2;
    localparam int unsigned NW = RW - DEFORM_FRACTION_BITS;

    logic [DENSITY_BITS-1:0] r_rest_density;
    logic [DENSITY_BITS-1:0] divisor;
    t_vms_ctl                q_ctl, root_ctl, quo_ctl;
    logic [QW-1:0]           q;
    logic [RW-1:0]           root;
    logic [NW-1:0]           quo;
    logic [63:0]             quo64;
    logic                    r_strobe;
    t_vms_out                r_result;

    // never stall the source: every stage advances every cycle
    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rest_density <= REST_DENSITY_RESET;
        end else if (i_cfg_we) begin
            r_rest_density <= i_cfg_wdata;
        end
    end

    // treat a zero rest density as one
    assign divisor = (r_rest_density == '0) ? DENSITY_BITS'(1) : r_rest_density;

    vms_cauchy #(.E(ELEMENT_BITS), .QW(QW)) u_cauchy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start & ~busy),
        .i_item  (i_item),
        .o_ctl   (q_ctl),
        .o_q     (q)
    );

    vms_isqrt #(.QW(QW)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (q_ctl),
        .i_q     (q),
        .o_ctl   (root_ctl),
        .o_root  (root)
    );

    vms_div #(.RW(RW), .F(DEFORM_FRACTION_BITS)) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (root_ctl),
        .i_root    (root),
        .i_divisor (divisor),
        .o_ctl     (quo_ctl),
        .o_quo     (quo)
    );

    // saturate when any quotient bit lies above the 32-bit result
    assign quo64 = 64'(quo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= quo_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result.result_tag <= quo_ctl.tag;
        if (|quo64[63:RESULT_BITS]) begin
            r_result.equivalent_stress <= '1;
            r_result.saturated         <= 1'b1;
        end else begin
            r_result.equivalent_stress <= quo64[RESULT_BITS-1:0];
            r_result.saturated         <= 1'b0;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
